// ----- rtl/core/ffha_pkg.sv -----
// Package for the first-fit heap allocator: sizes, codes, record layout,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package ffha_pkg;

  localparam int HEAP_BYTES   = 262144;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 8192;

  localparam int OFS_W    = 18;
  localparam int REQ_W    = 19;
  localparam int NEED_W   = REQ_W + 1;
  localparam int CMP_W    = NEED_W + 1;
  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int NXT_W    = IDX_W + 1;
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

  localparam logic [NXT_W-1:0] END_MARK = NXT_W'(MAX_BLOCKS);

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic [OFS_W-1:0] hdr;
    logic [OFS_W-1:0] size;
    logic             free;
    logic [NXT_W-1:0] nxt;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE, S_A_CHK, S_A_SPLIT, S_A_FIN, S_F_CHK, S_M_LD, S_M_CHK
  } state_t;

  typedef enum logic [1:0] {RD_NONE, RD_HEAD, RD_NEXT} rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_SET_USED, WR_SET_FREE, WR_NEW, WR_SPLIT, WR_MERGE
  } wr_sel_t;

  typedef enum logic [1:0] {OFS_ZERO, OFS_RQ, OFS_CW} ofs_sel_t;

  typedef struct packed {
    logic       latch;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    logic       ld_cur;
    logic       pop;
    logic       push;
    logic       resp;
    logic [1:0] resp_status;
    ofs_sel_t   ofs_sel;
  } cmd_t;

  typedef struct packed {
    logic in_null;
    logic in_free;
    logic fit;
    logic split_ok;
    logic rq_end;
    logic hit;
    logic merge_ok;
  } stat_t;

endpackage

// ----- rtl/core/ffha_ctrl.sv -----
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg; drives the datapath ffha_dp through cmd_t and reads stat_t.
module ffha_ctrl import ffha_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && !stat.in_null) begin
          state_nxt = stat.in_free ? S_F_CHK : S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (stat.fit) begin
          state_nxt = stat.split_ok ? S_A_SPLIT : S_IDLE;
        end else if (stat.rq_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_A_SPLIT: state_nxt = S_A_FIN;
      S_A_FIN:   state_nxt = S_IDLE;
      S_F_CHK: begin
        if (stat.hit) begin
          state_nxt = S_M_LD;
        end else if (stat.rq_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_M_LD: state_nxt = stat.rq_end ? S_IDLE : S_M_CHK;
      S_M_CHK: begin
        if (stat.rq_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_NONE;
    cmd.wr_sel      = WR_NONE;
    cmd.resp_status = ST_OK;
    cmd.ofs_sel     = OFS_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (stat.in_null) begin
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_NULL;
          end else begin
            cmd.rd_sel = RD_HEAD;
          end
        end
      end
      S_A_CHK: begin
        if (stat.fit) begin
          if (stat.split_ok) begin
            cmd.pop    = 1'b1;
            cmd.ld_cur = 1'b1;
          end else begin
            cmd.wr_sel  = WR_SET_USED;
            cmd.resp    = 1'b1;
            cmd.ofs_sel = OFS_RQ;
          end
        end else if (stat.rq_end) begin
          cmd.resp        = 1'b1;
          cmd.resp_status = ST_OOM;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_A_SPLIT: cmd.wr_sel = WR_NEW;
      S_A_FIN: begin
        cmd.wr_sel  = WR_SPLIT;
        cmd.resp    = 1'b1;
        cmd.ofs_sel = OFS_CW;
      end
      S_F_CHK: begin
        if (stat.hit) begin
          cmd.wr_sel = WR_SET_FREE;
          cmd.rd_sel = RD_HEAD;
        end else if (stat.rq_end) begin
          cmd.resp        = 1'b1;
          cmd.resp_status = ST_BAD;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_M_LD: begin
        cmd.ld_cur = 1'b1;
        if (stat.rq_end) begin
          cmd.resp = 1'b1;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_M_CHK: begin
        if (stat.merge_ok) begin
          cmd.wr_sel = WR_MERGE;
          cmd.push   = 1'b1;
        end else begin
          cmd.ld_cur = 1'b1;
        end
        if (stat.rq_end) begin
          cmd.resp = 1'b1;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/ffha_dp.sv -----
// Datapath of the first-fit heap allocator: block record memory, spare record stack,
// head record registers, current record register and result registers. Depends on ffha_pkg.
module ffha_dp import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_func,
  input  logic [REQ_W-1:0]  in_req_size,
  input  logic [OFS_W-1:0]  in_ptr_offset,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic [OFS_W-1:0]  out_payload_offset
);

  rec_t             rec_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] stk_mem [MAX_BLOCKS];

  logic [NEED_W-1:0] need_r;
  logic [OFS_W-1:0]  ptr_r;
  rec_t              mem_q;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              src0_r;
  rec_t              cw_r;
  logic [IDX_W-1:0]  cur_idx_r;
  logic [OFS_W-1:0]  size0_r;
  logic              free0_r;
  logic [NXT_W-1:0]  next0_r;
  logic [IDX_W-1:0]  stk_q;
  logic [IDX_W-1:0]  stk_addr_r;
  logic              stk_init_r;
  logic [NXT_W-1:0]  count_r;
  logic [NXT_W-1:0]  low_r;
  logic              out_strobe_r;
  logic [1:0]        out_status_r;
  logic [OFS_W-1:0]  out_ofs_r;

  rec_t              rec0, rq, wr_word, merged;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx, rd_addr, pop_addr, nr;
  logic [NEED_W-1:0] need_nxt, req_up;
  logic [OFS_W-1:0]  ofs_val;

  assign req_up   = NEED_W'(in_req_size) + NEED_W'(ALIGN_BYTES - 1);
  assign need_nxt = (req_up >> ALIGN_SH) << ALIGN_SH;

  assign rec0 = '{hdr: '0, size: size0_r, free: free0_r, nxt: next0_r};
  assign rq   = src0_r ? rec0 : mem_q;
  assign nr   = stk_init_r ? (stk_addr_r + IDX_W'(1)) : stk_q;
  assign pop_addr = count_r[IDX_W-1:0] - IDX_W'(1);
  assign rd_addr  = (cmd.rd_sel == RD_HEAD) ? '0 : rq.nxt[IDX_W-1:0];

  assign merged = '{hdr:  cw_r.hdr,
                    size: cw_r.size + OFS_W'(HEADER_BYTES) + rq.size,
                    free: cw_r.free,
                    nxt:  rq.nxt};

  assign stat.in_null  = (in_func == FN_ALLOC) ? (in_req_size == '0) : (in_ptr_offset == '0);
  assign stat.in_free  = (in_func == FN_FREE);
  assign stat.fit      = rq.free && (NEED_W'(rq.size) >= need_r);
  assign stat.split_ok = (CMP_W'(rq.size) >= CMP_W'(need_r) + CMP_W'(HEADER_BYTES + ALIGN_BYTES))
                         && (count_r != '0);
  assign stat.rq_end   = (rq.nxt == END_MARK);
  assign stat.hit      = ((REQ_W'(rq.hdr) + REQ_W'(HEADER_BYTES)) == REQ_W'(ptr_r));
  assign stat.merge_ok = cw_r.free && rq.free;

  always_comb begin
    wr_en   = 1'b1;
    wr_idx  = rd_idx_r;
    wr_word = rq;
    unique case (cmd.wr_sel)
      WR_NONE:     wr_en = 1'b0;
      WR_SET_USED: wr_word.free = 1'b0;
      WR_SET_FREE: wr_word.free = 1'b1;
      WR_NEW: begin
        wr_idx  = nr;
        wr_word = '{hdr:  cw_r.hdr + OFS_W'(HEADER_BYTES) + OFS_W'(need_r),
                    size: cw_r.size - OFS_W'(need_r) - OFS_W'(HEADER_BYTES),
                    free: 1'b1,
                    nxt:  cw_r.nxt};
      end
      WR_SPLIT: begin
        wr_idx  = cur_idx_r;
        wr_word = '{hdr: cw_r.hdr, size: OFS_W'(need_r), free: 1'b0, nxt: NXT_W'(nr)};
      end
      WR_MERGE: begin
        wr_idx  = cur_idx_r;
        wr_word = merged;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd.ofs_sel)
      OFS_RQ:  ofs_val = rq.hdr + OFS_W'(HEADER_BYTES);
      OFS_CW:  ofs_val = cw_r.hdr + OFS_W'(HEADER_BYTES);
      default: ofs_val = '0;
    endcase
  end

  // Record 0 is the list head and lives in registers so that reset can set it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size0_r <= OFS_W'(HEAP_BYTES - HEADER_BYTES);
      free0_r <= 1'b1;
      next0_r <= END_MARK;
    end else if (wr_en && (wr_idx == '0)) begin
      size0_r <= wr_word.size;
      free0_r <= wr_word.free;
      next0_r <= wr_word.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx != '0)) begin
      rec_mem[wr_idx] <= wr_word;
    end
    if (cmd.rd_sel != RD_NONE) begin
      mem_q    <= rec_mem[rd_addr];
      rd_idx_r <= rd_addr;
      src0_r   <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      need_r <= need_nxt;
      ptr_r  <= in_ptr_offset;
    end
    if (cmd.wr_sel == WR_MERGE) begin
      cw_r <= merged;
    end else if (cmd.ld_cur) begin
      cw_r      <= rq;
      cur_idx_r <= rd_idx_r;
    end
  end

  // Unwritten stack entries (below low_r) are not read; a pop there gives its index plus one.
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      stk_q      <= stk_mem[pop_addr];
      stk_addr_r <= pop_addr;
      stk_init_r <= (NXT_W'(pop_addr) < low_r);
    end
    if (cmd.push && (count_r < NXT_W'(MAX_BLOCKS))) begin
      stk_mem[count_r[IDX_W-1:0]] <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= NXT_W'(MAX_BLOCKS - 1);
      low_r   <= NXT_W'(MAX_BLOCKS);
    end else if (cmd.pop) begin
      count_r <= count_r - NXT_W'(1);
    end else if (cmd.push && (count_r < NXT_W'(MAX_BLOCKS))) begin
      count_r <= count_r + NXT_W'(1);
      if (count_r < low_r) begin
        low_r <= count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.resp;
    end
    if (cmd.resp) begin
      out_status_r <= cmd.resp_status;
      out_ofs_r    <= ofs_val;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_ofs_r;

endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// Usage: a request transfers at a rising edge where start is high and busy is low.
// in_func selects allocate (in_req_size bytes) or free (payload at in_ptr_offset).
// Each request gives exactly one result, shown on out_status and out_payload_offset
// for one cycle while out_strobe is high; the receiver cannot stall it.
// A null request answers in the cycle after the transfer and busy stays low.
// Otherwise the controller walks the list and reads one block record per cycle
// from a record memory with a registered read port and a separate write port.
// Allocate stops at the first free record that fits and, if it splits, then writes
// the new remainder record and the shortened block. Free walks the list to the
// block, marks it free, then walks the whole list from the head merging neighbours.
// A new request is taken in the cycle after the last one's strobe is scheduled.
// Reset makes the heap one free block behind the first header, with all other
// records spare; no clearing pass is needed, the block is ready right after reset.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [REQ_W-1:0]  in_req_size,
  input  logic [OFS_W-1:0]  in_ptr_offset,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic [OFS_W-1:0]  out_payload_offset
);

  cmd_t  cmd;
  stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffha_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_func),
    .in_req_size        (in_req_size),
    .in_ptr_offset      (in_ptr_offset),
    .cmd                (cmd),
    .stat               (stat),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset)
  );

endmodule
